// ----- design/prf_pkg.sv -----
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants for the response frame parser
// Result record layout, error codes, frame offsets and the hex digit decoder.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int unsigned POS_W       = 17;
  localparam int unsigned SIZE_W      = POS_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [31:0] ASCII_MARK   = 32'h4430_3030;
  localparam logic [15:0] BIN_SUBHDR   = 16'hD000;
  localparam logic [15:0] PAY_IDX_MAX  = 16'd65533;

  // Frame offsets.
  localparam logic [POS_W-1:0] ASC_LEN_FIRST = 17'd14;
  localparam logic [POS_W-1:0] ASC_LEN_LAST  = 17'd17;
  localparam logic [POS_W-1:0] ASC_CMP_FIRST = 17'd18;
  localparam logic [POS_W-1:0] ASC_CMP_LAST  = 17'd21;
  localparam logic [POS_W-1:0] ASC_START     = 17'd22;
  localparam logic [POS_W-1:0] BIN_LEN_LO    = 17'd7;
  localparam logic [POS_W-1:0] BIN_LEN_HI    = 17'd8;
  localparam logic [POS_W-1:0] BIN_CMP_LO    = 17'd9;
  localparam logic [POS_W-1:0] BIN_CMP_HI    = 17'd10;
  localparam logic [POS_W-1:0] BIN_START     = 17'd11;
  localparam logic [POS_W-1:0] MARK_POS      = 17'd3;

  localparam logic [SIZE_W-1:0] ASC_HDR_SIZE = 18'd18;
  localparam logic [SIZE_W-1:0] BIN_HDR_SIZE = 18'd9;
  localparam logic [SIZE_W-1:0] ASC_MIN_SIZE = 18'd22;
  localparam logic [SIZE_W-1:0] BIN_MIN_SIZE = 18'd11;
  localparam logic [15:0]       ASC_MIN_LEN  = 16'd4;
  localparam logic [15:0]       BIN_MIN_LEN  = 16'd2;

  // Register indexes.
  localparam logic [0:0] REG_WRITE_RESPONSE = 1'b0;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_SHORT  = 3'd1,
    ERR_SUBHDR = 3'd2,
    ERR_LEN    = 3'd3,
    ERR_SIZE   = 3'd4,
    ERR_HEX    = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] index;
    logic        diag;
    logic        ascii;
    logic [15:0] completion;
    err_t        err;
    logic        last;
  } res_t;

  // Everything one input byte produces: one or two results.
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } pair_t;

  // Bit 4 flags a character that is not a hex digit; the nibble is then zero.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

// ----- design/prf_frame.sv -----
// ----------------------------------------------------------------------------
// prf_frame: per-frame state and result computation
// Tracks the byte position, captures header fields and forms the payload
// and status results for each accepted byte.
// ----------------------------------------------------------------------------
module prf_frame (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      frame_byte,
  input  logic            frame_last,
  input  logic            write_response,
  output logic            push,
  output prf_pkg::pair_t  push_pair
);
  import prf_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [23:0]      fb_r, fb_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      cmp_r, cmp_nxt;
  logic             lbad_r, lbad_nxt;
  logic             cbad_r, cbad_nxt;
  logic             ascii_r, ascii_nxt;

  logic [4:0]        hex;
  logic [POS_W-1:0]  start;
  logic [POS_W-1:0]  offs;
  logic              pay_ok;
  logic [SIZE_W-1:0] size;
  err_t              err;
  res_t              pay_res, stat_res;

  always_comb begin
    hex       = hex_nibble(frame_byte);
    fb_nxt    = fb_r;
    ascii_nxt = ascii_r;
    len_nxt   = len_r;
    cmp_nxt   = cmp_r;
    lbad_nxt  = lbad_r;
    cbad_nxt  = cbad_r;

    // Only the first three bytes are kept; the fourth only decides the mode.
    if (pos_r < MARK_POS) begin
      fb_nxt = {fb_r[15:0], frame_byte};
    end
    if (pos_r == MARK_POS) begin
      ascii_nxt = ({fb_r, frame_byte} == ASCII_MARK);
    end

    if (ascii_nxt) begin
      start = ASC_START;
      if (pos_r >= ASC_LEN_FIRST && pos_r <= ASC_LEN_LAST) begin
        len_nxt  = {len_r[11:0], hex[3:0]};
        lbad_nxt = lbad_r | hex[4];
      end else if (pos_r >= ASC_CMP_FIRST && pos_r <= ASC_CMP_LAST) begin
        cmp_nxt  = {cmp_r[11:0], hex[3:0]};
        cbad_nxt = cbad_r | hex[4];
      end
    end else begin
      start = BIN_START;
      if (pos_r == BIN_LEN_LO) begin
        len_nxt = {len_r[15:8], frame_byte};
      end else if (pos_r == BIN_LEN_HI) begin
        len_nxt = {frame_byte, len_r[7:0]};
      end else if (pos_r == BIN_CMP_LO) begin
        cmp_nxt = {cmp_r[15:8], frame_byte};
      end else if (pos_r == BIN_CMP_HI) begin
        cmp_nxt = {frame_byte, cmp_r[7:0]};
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    offs    = pos_r - start;
    pay_ok  = (pos_r >= start) && (offs <= {1'b0, PAY_IDX_MAX});

    // A saturated counter reports one past its maximum, which never matches.
    size = (pos_r == POS_MAX) ? {1'b1, {POS_W{1'b0}}} : {1'b0, pos_r} + 1'b1;

    if (ascii_nxt) begin
      priority if (size < ASC_MIN_SIZE) begin
        err = ERR_SHORT;
      end else if (lbad_nxt) begin
        err = ERR_HEX;
      end else if (len_nxt < ASC_MIN_LEN) begin
        err = ERR_LEN;
      end else if (size != ASC_HDR_SIZE + {2'b00, len_nxt}) begin
        err = ERR_SIZE;
      end else if (cbad_nxt) begin
        err = ERR_HEX;
      end else begin
        err = ERR_OK;
      end
    end else begin
      priority if (size < BIN_MIN_SIZE) begin
        err = ERR_SHORT;
      end else if (fb_nxt[23:8] != BIN_SUBHDR) begin
        err = ERR_SUBHDR;
      end else if (len_nxt < BIN_MIN_LEN) begin
        err = ERR_LEN;
      end else if (size != BIN_HDR_SIZE + {2'b00, len_nxt}) begin
        err = ERR_SIZE;
      end else begin
        err = ERR_OK;
      end
    end

    pay_res.kind       = KIND_PAYLOAD;
    pay_res.value      = frame_byte;
    pay_res.index      = offs[15:0];
    pay_res.diag       = (cmp_nxt != 16'd0) || write_response;
    pay_res.ascii      = ascii_nxt;
    pay_res.completion = 16'd0;
    pay_res.err        = ERR_OK;
    pay_res.last       = ~frame_last;

    stat_res.kind       = KIND_STATUS;
    stat_res.value      = 8'd0;
    stat_res.index      = 16'd0;
    stat_res.diag       = 1'b0;
    stat_res.ascii      = ascii_nxt;
    stat_res.completion = (err == ERR_OK) ? cmp_nxt : 16'd0;
    stat_res.err        = err;
    stat_res.last       = 1'b1;

    push             = accept && (pay_ok || frame_last);
    push_pair.first  = pay_ok ? pay_res : stat_res;
    push_pair.second = stat_res;
    push_pair.two    = pay_ok && frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fb_r    <= '0;
      len_r   <= '0;
      cmp_r   <= '0;
      lbad_r  <= 1'b0;
      cbad_r  <= 1'b0;
      ascii_r <= 1'b0;
    end else if (accept) begin
      if (frame_last) begin
        pos_r   <= '0;
        fb_r    <= '0;
        len_r   <= '0;
        cmp_r   <= '0;
        lbad_r  <= 1'b0;
        cbad_r  <= 1'b0;
        ascii_r <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        fb_r    <= fb_nxt;
        len_r   <= len_nxt;
        cmp_r   <= cmp_nxt;
        lbad_r  <= lbad_nxt;
        cbad_r  <= cbad_nxt;
        ascii_r <= ascii_nxt;
      end
    end
  end

endmodule

// ----- design/prf_out_queue.sv -----
// ----------------------------------------------------------------------------
// prf_out_queue: result queue
// Holds the results of accepted bytes and hands them out one per transfer.
// ----------------------------------------------------------------------------
module prf_out_queue #(
  parameter int unsigned DEPTH = prf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prf_pkg::pair_t push_pair,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output prf_pkg::res_t  out_res
);
  import prf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pair_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sub_r, sub_nxt;
  logic             pop_res, pop_entry;
  pair_t            head;

  always_comb begin
    head      = mem_r[rd_r];
    full      = (cnt_r == CNT_FULL);
    out_valid = (cnt_r != '0);
    out_res   = sub_r ? head.second : head.first;

    pop_res   = out_valid && out_ready;
    // The entry leaves with its last result.
    pop_entry = pop_res && (sub_r || !head.two);

    sub_nxt = sub_r;
    if (pop_res) begin
      sub_nxt = !pop_entry;
    end

    wr_nxt = wr_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
    end
    rd_nxt = rd_r;
    if (pop_entry) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
    end

    cnt_nxt = cnt_r;
    unique case ({push, pop_entry})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_pair;
    end
  end

endmodule

// ----- design/plc_response_frame_parser.sv -----
// Each result is written into the result queue and offered from there.
// Throughput: one byte per cycle; a final byte that also carries payload
// yields two results, which leave over two output transfers.
// The input is held off only while the result queue is full.
// Reset: synchronous, active low; clears the frame state, the queue and
// the write_response register.
// ----------------------------------------------------------------------------
// plc_response_frame_parser: response frame parser top level
// Byte-wide frame parser with an APB-style register port and a result queue.
// ----------------------------------------------------------------------------
module plc_response_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = prf_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_frame_byte,
  input  logic                           in_frame_last,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_result_kind,
  output logic [7:0]                     out_payload_value,
  output logic [15:0]                    out_payload_index,
  output logic                           out_is_diagnostic,
  output logic                           out_ascii_framing,
  output logic [15:0]                    out_completion_value,
  output logic [2:0]                     out_error_code,
  output logic                           out_last_of_run,
  // Configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [prf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import prf_pkg::*;

  logic  write_response_r;
  logic  cfg_wr;
  logic  accept;
  logic  full;
  logic  push;
  pair_t push_pair;
  res_t  out_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_ADDR_W-1:2] == REG_WRITE_RESPONSE);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WRITE_RESPONSE) ?
                      {31'd0, write_response_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_response_r <= 1'b0;
    end else if (cfg_wr) begin
      write_response_r <= cfg_pwdata[0];
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  prf_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .frame_byte     (in_frame_byte),
    .frame_last     (in_frame_last),
    .write_response (write_response_r),
    .push           (push),
    .push_pair      (push_pair)
  );

  prf_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_result_kind      = out_res.kind;
  assign out_payload_value    = out_res.value;
  assign out_payload_index    = out_res.index;
  assign out_is_diagnostic    = out_res.diag;
  assign out_ascii_framing    = out_res.ascii;
  assign out_completion_value = out_res.completion;
  assign out_error_code       = out_res.err;
  assign out_last_of_run      = out_res.last;

endmodule

// ----- design/prf_checker.sv -----
// ----------------------------------------------------------------------------
// prf_checker: port-level checks for the response frame parser
// Watches the result channel and flags malformed or unstable results.
// ----------------------------------------------------------------------------
module prf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [7:0]  out_payload_value,
  input logic [15:0] out_payload_index,
  input logic [15:0] out_completion_value,
  input logic [2:0]  out_error_code,
  input logic        out_last_of_run
);
  import prf_pkg::*;

  // A stalled transfer keeps its payload value, payload index and error code.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_value) &&
      $stable(out_payload_index) && $stable(out_error_code))
    else $error("result changed while stalled");

  // A status result always closes the run of its byte.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |-> out_last_of_run)
    else $error("status result not marked last");

  // A failed frame reports no completion code.
  a_err_no_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_OK |-> out_completion_value == 16'd0)
    else $error("completion reported with an error");

  // Payload results carry neither status field.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |->
      out_error_code == ERR_OK && out_completion_value == 16'd0)
    else $error("payload result carries status fields");

  // Payload indexes stay within the payload range.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |-> out_payload_index <= PAY_IDX_MAX)
    else $error("payload index out of range");

endmodule

bind plc_response_frame_parser prf_checker u_prf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_result_kind      (out_result_kind),
  .out_payload_value    (out_payload_value),
  .out_payload_index    (out_payload_index),
  .out_completion_value (out_completion_value),
  .out_error_code       (out_error_code),
  .out_last_of_run      (out_last_of_run)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for plc_response_frame_parser
// Sends binary and ASCII response frames byte by byte with random gaps and
// output stalls, predicts every payload and status result in the testbench,
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import prf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WRITE_RESPONSE = {REG_WRITE_RESPONSE, 2'b00};

  localparam logic [31:0] ASCII_TAG       = "D000";
  localparam logic [16:0] POSITION_CAP    = 17'h1FFFF;
  localparam logic [16:0] INDEX_LIMIT     = 17'd65533;
  localparam int          RANDOM_BYTES    = 600;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          SHOWN_ERRORS    = 10;

  // Letter case used for hex fields of ASCII frames.
  localparam int HEX_UPPER = 0;
  localparam int HEX_LOWER = 1;
  localparam int HEX_MIXED = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_frame_byte;
  logic        in_frame_last;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_value;
  logic [15:0] out_payload_index;
  logic        out_is_diagnostic;
  logic        out_ascii_framing;
  logic [15:0] out_completion_value;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  plc_response_frame_parser DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_frame_byte        (in_frame_byte),
    .in_frame_last        (in_frame_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_payload_value    (out_payload_value),
    .out_payload_index    (out_payload_index),
    .out_is_diagnostic    (out_is_diagnostic),
    .out_ascii_framing    (out_ascii_framing),
    .out_completion_value (out_completion_value),
    .out_error_code       (out_error_code),
    .out_last_of_run      (out_last_of_run),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame tracking state of the predictor.
  logic [16:0] fp_pos = '0;
  logic [31:0] fp_head = '0;
  logic [15:0] fp_len = '0;
  logic [15:0] fp_cmp = '0;
  logic        fp_len_bad = 1'b0;
  logic        fp_cmp_bad = 1'b0;
  logic        fp_ascii = 1'b0;
  logic        reg_write_response = 1'b0;

  res_t        due_results[$];
  logic [7:0]  frame_buf[$];
  int          fail_count = 0;
  int          burst_left = 0;
  logic [15:0] rx_pat = 16'hFFFF;
  logic [5:0]  rx_tick = '0;
  int          quiet_cycles = 0;
  res_t        got_r;
  res_t        want_r;

  // Bit 4 is set for a character that is not a hex digit.
  function automatic logic [4:0] hex_code(input logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else begin
      return 5'h10;
    end
    return {1'b0, d[3:0]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input int mode);
    logic lower;
    lower = (mode == HEX_LOWER) || (mode == HEX_MIXED && $urandom_range(0, 1) == 1);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic string show_result(input res_t r);
    return $sformatf("kind=%0d value=%02h index=%0d diag=%0d ascii=%0d cmp=%04h err=%0d last=%0d",
                     r.kind, r.value, r.index, r.diag, r.ascii, r.completion, r.err, r.last);
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Works out the results of one accepted byte and queues them.
  task automatic decode_frame_byte(input logic [7:0] b, input logic last);
    logic [16:0] p;
    logic [16:0] start;
    logic [17:0] size;
    logic [4:0]  h;
    res_t        r;
    err_t        e;
    p = fp_pos;
    if (p < 17'd4) begin
      fp_head = {fp_head[23:0], b};
      if (p == 17'd3) fp_ascii = (fp_head == ASCII_TAG);
    end
    if (fp_ascii) begin
      h = hex_code(b);
      if (p >= 17'd14 && p <= 17'd17) begin
        fp_len = {fp_len[11:0], h[3:0]};
        fp_len_bad = fp_len_bad | h[4];
      end else if (p >= 17'd18 && p <= 17'd21) begin
        fp_cmp = {fp_cmp[11:0], h[3:0]};
        fp_cmp_bad = fp_cmp_bad | h[4];
      end
      start = 17'd22;
    end else begin
      case (p)
        17'd7:   fp_len[7:0] = b;
        17'd8:   fp_len[15:8] = b;
        17'd9:   fp_cmp[7:0] = b;
        17'd10:  fp_cmp[15:8] = b;
        default: ;
      endcase
      start = 17'd11;
    end
    if (p != POSITION_CAP) fp_pos = p + 17'd1;

    if (p >= start && (p - start) <= INDEX_LIMIT) begin
      r.kind = KIND_PAYLOAD;
      r.value = b;
      r.index = 16'(p - start);
      r.diag = (fp_cmp != 16'd0) || reg_write_response;
      r.ascii = fp_ascii;
      r.completion = 16'd0;
      r.err = ERR_OK;
      r.last = !last;
      due_results.push_back(r);
    end

    if (last) begin
      // A saturated counter stands for a frame longer than any legal one.
      size = (p == POSITION_CAP) ? 18'h20000 : {1'b0, p} + 18'd1;
      if (fp_ascii) begin
        if (size < 18'd22) e = ERR_SHORT;
        else if (fp_len_bad) e = ERR_HEX;
        else if (fp_len < 16'd4) e = ERR_LEN;
        else if (size != 18'd18 + {2'b00, fp_len}) e = ERR_SIZE;
        else if (fp_cmp_bad) e = ERR_HEX;
        else e = ERR_OK;
      end else begin
        if (size < 18'd11) e = ERR_SHORT;
        else if (fp_head[31:16] != 16'hD000) e = ERR_SUBHDR;
        else if (fp_len < 16'd2) e = ERR_LEN;
        else if (size != 18'd9 + {2'b00, fp_len}) e = ERR_SIZE;
        else e = ERR_OK;
      end
      r.kind = KIND_STATUS;
      r.value = 8'd0;
      r.index = 16'd0;
      r.diag = 1'b0;
      r.ascii = fp_ascii;
      r.completion = (e == ERR_OK) ? fp_cmp : 16'd0;
      r.err = e;
      r.last = 1'b1;
      due_results.push_back(r);
      fp_pos = '0;
      fp_head = '0;
      fp_len = '0;
      fp_cmp = '0;
      fp_len_bad = 1'b0;
      fp_cmp_bad = 1'b0;
      fp_ascii = 1'b0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_frame_byte <= b;
    in_frame_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_frame_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Quiet the input and let every outstanding result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_config(input logic v);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_WRITE_RESPONSE;
    cfg_pwdata <= {31'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    reg_write_response = v;
    // Read the register back in the next transfer.
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[0] !== v) begin
      flag_error($sformatf("write_response read back %0b, expected %0b", cfg_prdata[0], v));
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic push_hex16(input logic [15:0] v, input int mode);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(hex_char(v[i*4 +: 4], mode));
  endtask

  task automatic build_binary(input int pay_n, input logic [15:0] cmp);
    logic [15:0] len;
    len = 16'(pay_n + 2);
    frame_buf.delete();
    frame_buf.push_back(8'hD0);
    frame_buf.push_back(8'h00);
    repeat (5) frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(len[7:0]);
    frame_buf.push_back(len[15:8]);
    frame_buf.push_back(cmp[7:0]);
    frame_buf.push_back(cmp[15:8]);
    repeat (pay_n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_ascii(input int pay_n, input logic [15:0] cmp, input int mode);
    frame_buf.delete();
    frame_buf.push_back("D");
    repeat (3) frame_buf.push_back("0");
    repeat (10) frame_buf.push_back(hex_char(4'($urandom_range(0, 15)), mode));
    push_hex16(16'(pay_n + 4), mode);
    push_hex16(cmp, mode);
    repeat (pay_n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_binary_frames();
    build_binary(2, 16'h0000);
    frame_buf[11] = 8'h00;
    frame_buf[12] = 8'hFF;
    send_frame();
    build_binary(0, 16'hFFFF);
    send_frame();
    build_binary(1, 16'h0051);
    send_frame();
  endtask

  task automatic test_ascii_frames();
    build_ascii(2, 16'h0000, HEX_UPPER);
    frame_buf[22] = 8'hFF;
    frame_buf[23] = 8'h00;
    send_frame();
    build_ascii(0, 16'hC05F, HEX_LOWER);
    send_frame();
    build_ascii(1, 16'hABCD, HEX_UPPER);
    send_frame();
  endtask

  task automatic test_short_frames();
    frame_buf = '{8'h44};
    send_frame();
    frame_buf = '{"D", "0", "0"};
    send_frame();
    frame_buf = '{"D", "0", "0", "0"};
    send_frame();
    build_ascii(0, 16'h0000, HEX_MIXED);
    void'(frame_buf.pop_back());
    send_frame();
    build_binary(0, 16'h0000);
    void'(frame_buf.pop_back());
    send_frame();
  endtask

  task automatic test_error_codes();
    build_binary(1, 16'h0000);
    frame_buf[1] = 8'h01;
    send_frame();
    build_binary(0, 16'h0000);
    frame_buf[7] = 8'h01;
    send_frame();
    build_binary(2, 16'h0000);
    frame_buf[7] = 8'h05;
    send_frame();
    build_ascii(1, 16'h0000, HEX_UPPER);
    frame_buf[15] = "G";
    send_frame();
    build_ascii(0, 16'h0000, HEX_UPPER);
    frame_buf[17] = "3";
    send_frame();
    build_ascii(2, 16'h0000, HEX_UPPER);
    void'(frame_buf.pop_back());
    send_frame();
    build_ascii(1, 16'h1234, HEX_UPPER);
    frame_buf[20] = ":";
    send_frame();
  endtask

  // Frames with several faults must report the one checked first.
  task automatic test_error_order();
    build_ascii(0, 16'h0000, HEX_UPPER);
    frame_buf[14] = "g";
    void'(frame_buf.pop_back());
    send_frame();
    build_ascii(0, 16'h0000, HEX_UPPER);
    frame_buf[17] = "3";
    frame_buf[15] = "/";
    send_frame();
    build_ascii(2, 16'h0000, HEX_LOWER);
    frame_buf[19] = "x";
    void'(frame_buf.pop_back());
    send_frame();
    build_binary(0, 16'h0000);
    frame_buf[0] = 8'h50;
    void'(frame_buf.pop_back());
    send_frame();
    build_binary(0, 16'h0000);
    frame_buf[0] = 8'h00;
    frame_buf[7] = 8'h00;
    send_frame();
  endtask

  task automatic test_write_response();
    write_config(1'b1);
    build_binary(2, 16'h0000);
    send_frame();
    build_ascii(1, 16'h0000, HEX_MIXED);
    send_frame();
    write_config(1'b0);
  endtask

  task automatic test_random_traffic();
    int sent;
    int frames;
    int pick;
    int pay_n;
    int n;
    logic [15:0] cmp;
    sent = 0;
    frames = 0;
    while (sent < RANDOM_BYTES) begin
      if (frames % 8 == 0) write_config(1'($urandom_range(0, 1)));
      frames++;
      pick = $urandom_range(0, 99);
      pay_n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      cmp = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
      if (pick < 90) begin
        if (pick % 2 == 0) build_binary(pay_n, cmp);
        else build_ascii(pay_n, cmp, HEX_MIXED);
        if (pick >= 70 && pick < 80) begin
          n = $urandom_range(1, frame_buf.size());
          while (frame_buf.size() > n) void'(frame_buf.pop_back());
        end else if (pick >= 80) begin
          frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end else begin
        n = $urandom_range(1, 30);
        frame_buf.delete();
        if ($urandom_range(0, 1) == 1) frame_buf = '{"D", "0", "0", "0"};
        while (frame_buf.size() < n) frame_buf.push_back(8'($urandom_range(0, 255)));
      end
      sent += frame_buf.size();
      send_frame();
    end
  endtask

  // Result sink: a stall pattern that rotates and is reloaded each time rx_tick wraps,
  // now and then with no stalls at all.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd0) begin
      rx_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      rx_pat <= {rx_pat[14:0], rx_pat[15]};
    end
    out_ready <= rx_pat[0];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_r.kind = kind_t'(out_result_kind);
      got_r.value = out_payload_value;
      got_r.index = out_payload_index;
      got_r.diag = out_is_diagnostic;
      got_r.ascii = out_ascii_framing;
      got_r.completion = out_completion_value;
      got_r.err = err_t'(out_error_code);
      got_r.last = out_last_of_run;
      if (due_results.size() == 0) begin
        flag_error({"unexpected result: ", show_result(got_r)});
      end else begin
        want_r = due_results.pop_front();
        if (got_r !== want_r) begin
          flag_error({"expected ", show_result(want_r), "\n       got      ",
                      show_result(got_r)});
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_frame_byte = 8'h00;
    in_frame_last = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = 32'd0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    write_config(1'b0);
    test_binary_frames();
    test_ascii_frames();
    test_short_frames();
    test_error_codes();
    test_error_order();
    test_write_response();
    test_random_traffic();

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- plc_response_frame_parser.f -----
design/prf_pkg.sv
design/prf_frame.sv
design/prf_out_queue.sv
design/plc_response_frame_parser.sv
design/prf_checker.sv
test/tb.sv
